FILE: rtl/core/clfs_pkg.sv
// Shared types, constants and codes of the checksummed link frame sequencer.
package clfs_pkg;

    localparam int RX_DEPTH = 16;
    localparam int IDX_W    = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int CNT_W    = $clog2(RX_DEPTH + 1);
    localparam logic [7:0] RX_DEPTH_B = 8'(RX_DEPTH);

    localparam int ADDR_W = 4;
    localparam int DATA_W = 32;

    localparam logic [1:0] REG_HELLO_LENGTH = 2'd0;
    localparam logic [1:0] REG_TX_LENGTH    = 2'd1;
    localparam logic [1:0] REG_RX_LENGTH    = 2'd2;

    localparam logic [7:0] BYTE_ONES = 8'hFF;
    localparam logic [7:0] BYTE_ZERO = 8'h00;

    localparam logic CMD_TX = 1'b0;
    localparam logic CMD_RX = 1'b1;

    typedef enum logic [1:0] {
        PH_HELLO = 2'd0,
        PH_RX    = 2'd1,
        PH_TX    = 2'd2
    } phase_t;

    typedef enum logic [2:0] {
        K_SEND   = 3'd0,
        K_ACCEPT = 3'd1,
        K_STOP   = 3'd2,
        K_REJECT = 3'd3,
        K_ERROR  = 3'd4
    } kind_t;

    typedef enum logic [2:0] {
        OSEL_ERR,
        OSEL_TX_BYTE,
        OSEL_TX_CSUM,
        OSEL_STOP,
        OSEL_REJECT,
        OSEL_REL
    } out_sel_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_EXEC,
        ST_CSUM,
        ST_REL_READ,
        ST_REL_OUT
    } state_t;

    typedef struct packed {
        logic       command;
        logic [7:0] data_byte;
    } in_item_t;

    typedef struct packed {
        kind_t      kind;
        logic [7:0] out_byte;
        logic       stop_with_byte;
        logic       last;
    } out_item_t;

    typedef struct packed {
        logic [7:0] hello_length;
        logic [7:0] tx_length;
        logic [4:0] rx_length;
    } cfg_t;

    typedef struct packed {
        logic     load_in;
        logic     upd_sum;
        logic     inc_count;
        logic     clr_frame;
        logic     set_phase;
        phase_t   phase_val;
        logic     mem_we;
        logic     mem_re;
        logic     rel_start;
        logic     rel_inc;
        logic     out_load;
        out_sel_t out_sel;
    } dp_cmd_t;

    typedef struct packed {
        logic can_load;
        logic is_tx;
        logic is_err;
        logic tx_final;
        logic rx_store;
        logic rx_stop;
        logic chk_ok;
        logic rel_last;
    } dp_status_t;

endpackage

FILE: rtl/core/clfs_regs.sv
// Configuration register file with its APB-style access port.
module clfs_regs (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [clfs_pkg::DATA_W-1:0]   pwdata,
    output logic [clfs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready,
    output clfs_pkg::cfg_t                cfg
);

    logic [7:0] hello_length_reg, hello_length_next;
    logic [7:0] tx_length_reg, tx_length_next;
    logic [4:0] rx_length_reg, rx_length_next;
    logic       wr_en;
    logic [1:0] index;

    assign pready = 1'b1;
    assign wr_en  = psel & penable & pwrite;
    assign index  = paddr[3:2];

    always_comb
    begin
        hello_length_next = hello_length_reg;
        tx_length_next    = tx_length_reg;
        rx_length_next    = rx_length_reg;
        if (wr_en)
        begin
            unique case (index)
                clfs_pkg::REG_HELLO_LENGTH: hello_length_next = pwdata[7:0];
                clfs_pkg::REG_TX_LENGTH:    tx_length_next    = pwdata[7:0];
                clfs_pkg::REG_RX_LENGTH:    rx_length_next    = pwdata[4:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            hello_length_reg <= 8'd48;
            tx_length_reg    <= 8'd8;
            rx_length_reg    <= 5'd12;
        end
        else
        begin
            hello_length_reg <= hello_length_next;
            tx_length_reg    <= tx_length_next;
            rx_length_reg    <= rx_length_next;
        end
    end

    always_comb
    begin
        unique case (index)
            clfs_pkg::REG_HELLO_LENGTH: prdata = {24'd0, hello_length_reg};
            clfs_pkg::REG_TX_LENGTH:    prdata = {24'd0, tx_length_reg};
            clfs_pkg::REG_RX_LENGTH:    prdata = {27'd0, rx_length_reg};
            default:                    prdata = '0;
        endcase
    end

    assign cfg.hello_length = hello_length_reg;
    assign cfg.tx_length    = tx_length_reg;
    assign cfg.rx_length    = rx_length_reg;

endmodule

FILE: rtl/core/clfs_ctrl.sv
// Sequencing state machine: steps one transaction through its results.
module clfs_ctrl (
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  item_valid,
    output logic                  item_ready,
    input  clfs_pkg::dp_status_t  st,
    output clfs_pkg::dp_cmd_t     cmd
);

    clfs_pkg::state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            state_reg <= clfs_pkg::ST_IDLE;
        else
            state_reg <= state_next;
    end

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            clfs_pkg::ST_IDLE:
            begin
                if (item_valid)
                    state_next = clfs_pkg::ST_EXEC;
            end
            clfs_pkg::ST_EXEC:
            begin
                if (st.can_load)
                begin
                    priority if (st.is_err)
                        state_next = clfs_pkg::ST_IDLE;
                    else if (st.is_tx)
                        state_next = st.tx_final ? clfs_pkg::ST_CSUM : clfs_pkg::ST_IDLE;
                    else if (st.rx_store)
                        state_next = clfs_pkg::ST_IDLE;
                    else if (st.chk_ok)
                        state_next = clfs_pkg::ST_REL_READ;
                    else
                        state_next = clfs_pkg::ST_IDLE;
                end
            end
            clfs_pkg::ST_CSUM:
            begin
                if (st.can_load)
                    state_next = clfs_pkg::ST_IDLE;
            end
            clfs_pkg::ST_REL_READ:
                state_next = clfs_pkg::ST_REL_OUT;
            clfs_pkg::ST_REL_OUT:
            begin
                if (st.can_load)
                    state_next = st.rel_last ? clfs_pkg::ST_IDLE : clfs_pkg::ST_REL_READ;
            end
            default:
                state_next = clfs_pkg::ST_IDLE;
        endcase
    end

    always_comb
    begin
        cmd        = '0;
        cmd.phase_val = clfs_pkg::PH_TX;
        cmd.out_sel   = clfs_pkg::OSEL_ERR;
        item_ready = 1'b0;
        unique case (state_reg)
            clfs_pkg::ST_IDLE:
            begin
                item_ready  = 1'b1;
                cmd.load_in = item_valid;
            end
            clfs_pkg::ST_EXEC:
            begin
                if (st.can_load)
                begin
                    priority if (st.is_err)
                    begin
                        cmd.out_load = 1'b1;
                        cmd.out_sel  = clfs_pkg::OSEL_ERR;
                    end
                    else if (st.is_tx)
                    begin
                        cmd.upd_sum   = 1'b1;
                        cmd.out_load  = 1'b1;
                        cmd.out_sel   = clfs_pkg::OSEL_TX_BYTE;
                        cmd.inc_count = ~st.tx_final;
                    end
                    else if (st.rx_store)
                    begin
                        cmd.mem_we    = 1'b1;
                        cmd.upd_sum   = 1'b1;
                        cmd.inc_count = 1'b1;
                        cmd.out_load  = st.rx_stop;
                        cmd.out_sel   = clfs_pkg::OSEL_STOP;
                    end
                    else
                    begin
                        // checksum byte closes the receive frame
                        cmd.clr_frame = 1'b1;
                        cmd.set_phase = 1'b1;
                        cmd.phase_val = clfs_pkg::PH_TX;
                        cmd.rel_start = st.chk_ok;
                        cmd.out_load  = ~st.chk_ok;
                        cmd.out_sel   = clfs_pkg::OSEL_REJECT;
                    end
                end
            end
            clfs_pkg::ST_CSUM:
            begin
                if (st.can_load)
                begin
                    cmd.out_load  = 1'b1;
                    cmd.out_sel   = clfs_pkg::OSEL_TX_CSUM;
                    cmd.clr_frame = 1'b1;
                    cmd.set_phase = 1'b1;
                    cmd.phase_val = clfs_pkg::PH_RX;
                end
            end
            clfs_pkg::ST_REL_READ:
                cmd.mem_re = 1'b1;
            clfs_pkg::ST_REL_OUT:
            begin
                if (st.can_load)
                begin
                    cmd.out_load = 1'b1;
                    cmd.out_sel  = clfs_pkg::OSEL_REL;
                    cmd.rel_inc  = ~st.rel_last;
                end
            end
            default: ;
        endcase
    end

endmodule

FILE: rtl/core/clfs_dp.sv
// Datapath: frame counters, byte sum, receive memory and result register.
module clfs_dp (
    input  logic                  clk,
    input  logic                  rst_n,
    input  clfs_pkg::cfg_t        cfg,
    input  clfs_pkg::in_item_t    item,
    output logic                  result_valid,
    input  logic                  result_ready,
    output clfs_pkg::out_item_t   result,
    input  clfs_pkg::dp_cmd_t     cmd,
    output clfs_pkg::dp_status_t  st
);

    clfs_pkg::phase_t phase_reg, phase_next;
    logic [7:0] byte_count_reg, byte_count_next;
    logic [7:0] running_sum_reg, running_sum_next;
    logic [clfs_pkg::CNT_W-1:0] rel_idx_reg, rel_idx_next;
    logic [clfs_pkg::CNT_W-1:0] rel_len_reg, rel_len_next;
    logic       out_valid_reg, out_valid_next;
    clfs_pkg::out_item_t out_data_reg, out_data_next;
    clfs_pkg::in_item_t  in_reg;

    logic [7:0] store_mem [clfs_pkg::RX_DEPTH];
    logic [7:0] rd_data_reg;

    logic [7:0] tx_len_sel;
    logic [7:0] tx_len_eff;
    logic [7:0] rx_len_ext;
    logic [7:0] rx_len_eff;
    logic [8:0] count_inc;
    logic [7:0] sum_add;

    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
            in_reg <= item;
    end

    assign tx_len_sel = (phase_reg == clfs_pkg::PH_HELLO) ? cfg.hello_length : cfg.tx_length;
    assign tx_len_eff = (tx_len_sel == 8'd0) ? 8'd1 : tx_len_sel;
    assign rx_len_ext = {3'd0, cfg.rx_length};

    always_comb
    begin
        priority if (rx_len_ext == 8'd0)
            rx_len_eff = 8'd1;
        else if (rx_len_ext > clfs_pkg::RX_DEPTH_B)
            rx_len_eff = clfs_pkg::RX_DEPTH_B;
        else
            rx_len_eff = rx_len_ext;
    end

    assign count_inc = {1'b0, byte_count_reg} + 9'd1;
    assign sum_add   = running_sum_reg + in_reg.data_byte;

    assign st.can_load = ~out_valid_reg | result_ready;
    assign st.is_tx    = (phase_reg != clfs_pkg::PH_RX);
    assign st.is_err   = st.is_tx ? (in_reg.command != clfs_pkg::CMD_TX)
                                  : (in_reg.command != clfs_pkg::CMD_RX);
    assign st.tx_final = count_inc >= {1'b0, tx_len_eff};
    assign st.rx_store = byte_count_reg < rx_len_eff;
    assign st.rx_stop  = count_inc == {1'b0, rx_len_eff};
    assign st.chk_ok   = in_reg.data_byte == (running_sum_reg ^ clfs_pkg::BYTE_ONES);
    assign st.rel_last = ({1'b0, rel_idx_reg} + (clfs_pkg::CNT_W+1)'(1))
                         == {1'b0, rel_len_reg};

    always_comb
    begin
        phase_next       = phase_reg;
        byte_count_next  = byte_count_reg;
        running_sum_next = running_sum_reg;
        rel_idx_next     = rel_idx_reg;
        rel_len_next     = rel_len_reg;
        if (cmd.upd_sum)
            running_sum_next = sum_add;
        if (cmd.inc_count)
            byte_count_next = count_inc[7:0];
        if (cmd.clr_frame)
        begin
            byte_count_next  = 8'd0;
            running_sum_next = 8'd0;
        end
        if (cmd.set_phase)
            phase_next = cmd.phase_val;
        if (cmd.rel_start)
        begin
            rel_idx_next = '0;
            rel_len_next = rx_len_eff[clfs_pkg::CNT_W-1:0];
        end
        if (cmd.rel_inc)
            rel_idx_next = rel_idx_reg + clfs_pkg::CNT_W'(1);
    end

    always_comb
    begin
        out_data_next = out_data_reg;
        if (cmd.out_load)
        begin
            out_data_next.stop_with_byte = 1'b0;
            out_data_next.last           = 1'b1;
            out_data_next.out_byte       = clfs_pkg::BYTE_ZERO;
            unique case (cmd.out_sel)
                clfs_pkg::OSEL_ERR:
                    out_data_next.kind = clfs_pkg::K_ERROR;
                clfs_pkg::OSEL_TX_BYTE:
                begin
                    out_data_next.kind     = clfs_pkg::K_SEND;
                    out_data_next.out_byte = in_reg.data_byte;
                    out_data_next.last     = ~st.tx_final;
                end
                clfs_pkg::OSEL_TX_CSUM:
                begin
                    // sum already includes the final payload byte
                    out_data_next.kind           = clfs_pkg::K_SEND;
                    out_data_next.out_byte       = running_sum_reg ^ clfs_pkg::BYTE_ONES;
                    out_data_next.stop_with_byte = 1'b1;
                end
                clfs_pkg::OSEL_STOP:
                    out_data_next.kind = clfs_pkg::K_STOP;
                clfs_pkg::OSEL_REJECT:
                    out_data_next.kind = clfs_pkg::K_REJECT;
                clfs_pkg::OSEL_REL:
                begin
                    out_data_next.kind     = clfs_pkg::K_ACCEPT;
                    out_data_next.out_byte = rd_data_reg;
                    out_data_next.last     = st.rel_last;
                end
                default:
                    out_data_next.kind = clfs_pkg::K_ERROR;
            endcase
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
            out_valid_next = 1'b1;
        else if (result_ready)
            out_valid_next = 1'b0;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg       <= clfs_pkg::PH_HELLO;
            byte_count_reg  <= 8'd0;
            running_sum_reg <= 8'd0;
            rel_idx_reg     <= '0;
            rel_len_reg     <= '0;
            out_valid_reg   <= 1'b0;
        end
        else
        begin
            phase_reg       <= phase_next;
            byte_count_reg  <= byte_count_next;
            running_sum_reg <= running_sum_next;
            rel_idx_reg     <= rel_idx_next;
            rel_len_reg     <= rel_len_next;
            out_valid_reg   <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_data_reg <= out_data_next;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.mem_we)
            store_mem[byte_count_reg[clfs_pkg::IDX_W-1:0]] <= in_reg.data_byte;
        if (cmd.mem_re)
            rd_data_reg <= store_mem[rel_idx_reg[clfs_pkg::IDX_W-1:0]];
    end

    assign result_valid = out_valid_reg;
    assign result       = out_data_reg;

`ifndef SYNTHESIS
    a_load_into_free_slot: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.out_load |-> (!out_valid_reg || result_ready))
        else $error("result register overwritten while still pending");

    a_store_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.mem_we |-> (byte_count_reg < clfs_pkg::RX_DEPTH_B))
        else $error("receive store written beyond its depth");

    a_release_in_range: assert property (@(posedge clk) disable iff (!rst_n)
        (cmd.mem_re || cmd.rel_inc) |-> (rel_idx_reg < rel_len_reg))
        else $error("release index ran past frame length");

    a_release_step_with_load: assert property (@(posedge clk) disable iff (!rst_n)
        cmd.rel_inc |-> (cmd.out_load && cmd.out_sel == clfs_pkg::OSEL_REL))
        else $error("release index advanced without emitting a byte");
`endif

endmodule

FILE: rtl/core/checksummed_link_frame_sequencer.sv
// Top level of the checksummed link frame sequencer.
// Master-side framer for a byte link: a hello transmit frame of hello_length
// bytes after reset, then alternating receive (rx_length bytes, capped at the
// memory depth, plus checksum) and transmit (tx_length bytes plus inverted-sum
// checksum with stop) frames; zero lengths count as one. Each transaction is
// accepted, then executed once the result register is free; the last transmit
// payload byte adds a checksum state, and a matching receive checksum releases
// the stored frame byte by byte through a read state (registered read port of
// the receive memory) and an output state. The memory needs no clearing after
// reset, so the block is ready as soon as reset is released. Configuration is
// APB-style at byte addresses 0, 4 and 8 (hello_length, tx_length, rx_length).
module checksummed_link_frame_sequencer (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    output logic                          item_ready,
    input  clfs_pkg::in_item_t            item,
    output logic                          result_valid,
    input  logic                          result_ready,
    output clfs_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [clfs_pkg::DATA_W-1:0]   pwdata,
    output logic [clfs_pkg::DATA_W-1:0]   prdata,
    output logic                          pready
);

    clfs_pkg::cfg_t       cfg;
    clfs_pkg::dp_cmd_t    cmd;
    clfs_pkg::dp_status_t st;

    clfs_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    clfs_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_ready (item_ready),
        .st         (st),
        .cmd        (cmd)
    );

    clfs_dp u_dp (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg          (cfg),
        .item         (item),
        .result_valid (result_valid),
        .result_ready (result_ready),
        .result       (result),
        .cmd          (cmd),
        .st           (st)
    );

endmodule

FILE: sim/clfs_result_checker.sv
// Scoreboard for the link frame sequencer: tracks register writes, predicts results, compares.
`timescale 1ns / 1ps
module clfs_result_checker (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          item_valid,
    input  logic                          item_ready,
    input  clfs_pkg::in_item_t            item,
    input  logic                          result_valid,
    input  logic                          result_ready,
    input  clfs_pkg::out_item_t           result,
    input  logic                          psel,
    input  logic                          penable,
    input  logic                          pwrite,
    input  logic [clfs_pkg::ADDR_W-1:0]   paddr,
    input  logic [clfs_pkg::DATA_W-1:0]   pwdata,
    input  logic                          pready,
    output int                            fail_count,
    output int                            pending,
    output int                            results_seen
);
    import clfs_pkg::*;

    localparam logic [7:0] HELLO_LEN_RST = 8'd48;
    localparam logic [7:0] TX_LEN_RST    = 8'd8;
    localparam logic [4:0] RX_LEN_RST    = 5'd12;

    logic [7:0] hello_len;
    logic [7:0] tx_len;
    logic [4:0] rx_len;

    phase_t     link_phase;
    logic [7:0] frame_count;
    logic [7:0] frame_sum;
    logic [7:0] rx_store [RX_DEPTH];
    out_item_t  expected_results [$];

    task automatic expect_result(input kind_t k, input logic [7:0] b, input logic stop,
                                 input logic is_last);
        out_item_t r;
        r.kind           = k;
        r.out_byte       = b;
        r.stop_with_byte = stop;
        r.last           = is_last;
        expected_results.push_back(r);
    endtask

    task automatic predict_link_step(input in_item_t it);
        int len;
        int i;
        if (link_phase == PH_HELLO || link_phase == PH_TX) begin
            if (it.command != CMD_TX) begin
                expect_result(K_ERROR, BYTE_ZERO, 1'b0, 1'b1);
            end
            else begin
                len = (link_phase == PH_HELLO) ? int'(hello_len) : int'(tx_len);
                if (len == 0)
                    len = 1;
                frame_sum = frame_sum + it.data_byte;
                if (int'(frame_count) + 1 >= len) begin
                    expect_result(K_SEND, it.data_byte, 1'b0, 1'b0);
                    expect_result(K_SEND, ~frame_sum, 1'b1, 1'b1);
                    link_phase  = PH_RX;
                    frame_count = 8'd0;
                    frame_sum   = 8'd0;
                end
                else begin
                    expect_result(K_SEND, it.data_byte, 1'b0, 1'b1);
                    frame_count = frame_count + 8'd1;
                end
            end
        end
        else begin
            len = int'(rx_len);
            if (len == 0)
                len = 1;
            if (len > RX_DEPTH)
                len = RX_DEPTH;
            if (it.command != CMD_RX) begin
                expect_result(K_ERROR, BYTE_ZERO, 1'b0, 1'b1);
            end
            else if (int'(frame_count) < len) begin
                rx_store[int'(frame_count) % RX_DEPTH] = it.data_byte;
                frame_sum   = frame_sum + it.data_byte;
                frame_count = frame_count + 8'd1;
                if (int'(frame_count) == len)
                    expect_result(K_STOP, BYTE_ZERO, 1'b0, 1'b1);
            end
            else begin
                // this byte is the checksum
                if (it.data_byte == ~frame_sum) begin
                    for (i = 0; i < len; i++)
                        expect_result(K_ACCEPT, rx_store[i], 1'b0, i == len - 1);
                end
                else begin
                    expect_result(K_REJECT, BYTE_ZERO, 1'b0, 1'b1);
                end
                link_phase  = PH_TX;
                frame_count = 8'd0;
                frame_sum   = 8'd0;
            end
        end
    endtask

    task automatic compare_result(input out_item_t got);
        out_item_t want;
        if (expected_results.size() == 0) begin
            $error("unexpected result: kind %0d, out_byte 0x%02h", got.kind, got.out_byte);
            fail_count++;
        end
        else begin
            want = expected_results.pop_front();
            if (got.kind !== want.kind) begin
                $error("kind: expected %0d, got %0d", want.kind, got.kind);
                fail_count++;
            end
            if (got.out_byte !== want.out_byte) begin
                $error("out_byte: expected 0x%02h, got 0x%02h", want.out_byte, got.out_byte);
                fail_count++;
            end
            if (got.stop_with_byte !== want.stop_with_byte) begin
                $error("stop_with_byte: expected %0b, got %0b",
                       want.stop_with_byte, got.stop_with_byte);
                fail_count++;
            end
            if (got.last !== want.last) begin
                $error("last: expected %0b, got %0b", want.last, got.last);
                fail_count++;
            end
        end
    endtask

    always @(posedge clk or negedge rst_n) begin
        if (!rst_n) begin
            hello_len    = HELLO_LEN_RST;
            tx_len       = TX_LEN_RST;
            rx_len       = RX_LEN_RST;
            link_phase   = PH_HELLO;
            frame_count  = 8'd0;
            frame_sum    = 8'd0;
            expected_results.delete();
            fail_count   = 0;
            results_seen = 0;
            pending     <= 0;
        end
        else begin
            if (psel && penable && pwrite && pready) begin
                case (paddr[ADDR_W-1:2])
                    REG_HELLO_LENGTH: hello_len = pwdata[7:0];
                    REG_TX_LENGTH:    tx_len    = pwdata[7:0];
                    REG_RX_LENGTH:    rx_len    = pwdata[4:0];
                    default: ;
                endcase
            end
            // results never leave in the same cycle their transaction is accepted, so compare first
            if (result_valid && result_ready) begin
                compare_result(result);
                results_seen++;
            end
            if (item_valid && item_ready)
                predict_link_step(item);
            pending <= expected_results.size();
        end
    end

endmodule

FILE: sim/tb_checksummed_link_frame_sequencer.sv
// Testbench top for the link frame sequencer: clock, reset, stimulus and verdict.
`timescale 1ns / 1ps
module tb_checksummed_link_frame_sequencer;
    import clfs_pkg::*;

    localparam int ITEMS_PER_PHASE = 80;
    localparam int NOISE_PCT       = 4;
    localparam int RESIZE_PCT      = 3;
    localparam int DRAIN_CYCLES    = 12;

    logic                clk          = 1'b0;
    logic                rst_n        = 1'b0;
    logic                item_valid   = 1'b0;
    logic                item_ready;
    in_item_t            item         = '0;
    logic                result_valid;
    logic                result_ready = 1'b0;
    out_item_t           result;
    logic                psel         = 1'b0;
    logic                penable      = 1'b0;
    logic                pwrite       = 1'b0;
    logic [ADDR_W-1:0]   paddr        = '0;
    logic [DATA_W-1:0]   pwdata       = '0;
    logic [DATA_W-1:0]   prdata;
    logic                pready;

    int fail_count;
    int pending;
    int results_seen;

    int src_gap_pct    = 0;
    int sink_stall_pct = 0;
    int n_sent         = 0;
    int n_phase_err    = 0;
    int n_good_rx      = 0;
    int n_bad_rx       = 0;
    int n_resize       = 0;

    // local copies of the transmit and receive length registers, used to shape well-formed frames
    logic [7:0] tx_cfg    = 8'd8;
    logic [4:0] rx_cfg    = 5'd12;
    logic       next_tx   = 1'b0;
    logic       resize_on = 1'b0;

    checksummed_link_frame_sequencer dut (.*);

    clfs_result_checker u_checker (.*);

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    always @(posedge clk)
        result_ready <= rst_n && (int'($urandom_range(99)) >= sink_stall_pct);

    task automatic reg_write(input logic [1:0] idx, input logic [7:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= {24'd0, value};
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx == REG_TX_LENGTH)
            tx_cfg = value;
        else if (idx == REG_RX_LENGTH)
            rx_cfg = value[4:0];
    endtask

    task automatic wait_drained();
        item_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        // middle receive bytes give no result but may still be in flight
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic send_item(input logic cmd, input logic [7:0] data);
        while (int'($urandom_range(99)) < src_gap_pct)
        begin
            item_valid <= 1'b0;
            @(posedge clk);
        end
        item_valid <= 1'b1;
        item       <= '{command: cmd, data_byte: data};
        @(posedge clk);
        while (!item_ready)
            @(posedge clk);
        n_sent++;
    endtask

    task automatic maybe_wrong_command(input logic cmd);
        if (int'($urandom_range(99)) < NOISE_PCT)
        begin
            send_item((cmd == CMD_TX) ? CMD_RX : CMD_TX, 8'($urandom_range(255)));
            n_phase_err++;
        end
    endtask

    function automatic logic [7:0] pick_tx_length();
        case ($urandom_range(9))
            0:       return 8'd0;
            1:       return 8'd1;
            2:       return 8'($urandom_range(9, 40));
            default: return 8'($urandom_range(2, 8));
        endcase
    endfunction

    function automatic logic [7:0] pick_rx_length();
        if ($urandom_range(9) < 6)
            return 8'($urandom_range(1, 6));
        return 8'($urandom_range(31));
    endfunction

    function automatic int tx_frame_len();
        int n;
        n = int'(tx_cfg);
        return (n == 0) ? 1 : n;
    endfunction

    function automatic int rx_frame_len();
        int n;
        n = int'(rx_cfg);
        if (n == 0)
            n = 1;
        if (n > RX_DEPTH)
            n = RX_DEPTH;
        return n;
    endfunction

    // length change between two bytes of a frame, with the block idle
    task automatic maybe_resize(input logic [1:0] idx);
        if (resize_on && int'($urandom_range(99)) < RESIZE_PCT)
        begin
            wait_drained();
            reg_write(idx, (idx == REG_RX_LENGTH) ? pick_rx_length() : pick_tx_length());
            n_resize++;
        end
    endtask

    task automatic tx_frame();
        int   count;
        logic done;
        count = 0;
        done  = 1'b0;
        while (!done)
        begin
            if (count > 0)
                maybe_resize(REG_TX_LENGTH);
            maybe_wrong_command(CMD_TX);
            send_item(CMD_TX, 8'($urandom_range(255)));
            count++;
            done = (count >= tx_frame_len());
        end
        next_tx = 1'b0;
    endtask

    task automatic rx_frame();
        int         count;
        logic       done;
        logic [7:0] sum;
        logic [7:0] b;
        logic [7:0] check;
        count = 0;
        done  = 1'b0;
        sum   = 8'd0;
        while (!done)
        begin
            if (count > 0)
                maybe_resize(REG_RX_LENGTH);
            if (count >= rx_frame_len())
            begin
                done = 1'b1;
            end
            else
            begin
                maybe_wrong_command(CMD_RX);
                b = 8'($urandom_range(255));
                send_item(CMD_RX, b);
                sum = sum + b;
                count++;
            end
        end
        check = ~sum;
        if ($urandom_range(3) == 0)
        begin
            check = check ^ 8'($urandom_range(1, 255));
            n_bad_rx++;
        end
        else
        begin
            n_good_rx++;
        end
        maybe_wrong_command(CMD_RX);
        send_item(CMD_RX, check);
        next_tx = 1'b1;
    endtask

    initial
    begin : stimulus
        logic [7:0] sum;
        int         p;
        int         phase_start;

        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // zero lengths behave as one
        reg_write(REG_HELLO_LENGTH, 8'd255);
        reg_write(REG_HELLO_LENGTH, 8'd0);
        reg_write(REG_TX_LENGTH, 8'd0);
        reg_write(REG_RX_LENGTH, 8'd0);

        send_item(CMD_RX, 8'hFF);        // wrong command during hello
        send_item(CMD_TX, 8'hFF);        // one-byte hello, checksum 0x00
        send_item(CMD_TX, 8'h00);        // wrong command during receive
        send_item(CMD_RX, 8'h00);
        send_item(CMD_RX, 8'hFF);        // matching checksum
        send_item(CMD_TX, 8'h00);
        send_item(CMD_RX, 8'hAA);
        send_item(CMD_RX, 8'hAA);        // checksum mismatch
        send_item(CMD_TX, 8'h7F);
        n_phase_err += 2;
        n_good_rx   += 1;
        n_bad_rx    += 1;

        wait_drained();
        reg_write(REG_TX_LENGTH, 8'd4);
        reg_write(REG_RX_LENGTH, 8'd5);

        // receive length shrinks below the bytes already taken: next byte is checksum
        send_item(CMD_RX, 8'h01);
        send_item(CMD_RX, 8'h80);
        send_item(CMD_RX, 8'h55);
        send_item(CMD_RX, 8'hFE);
        sum = 8'h01 + 8'h80 + 8'h55 + 8'hFE;
        wait_drained();
        reg_write(REG_RX_LENGTH, 8'd2);
        send_item(CMD_RX, ~sum);
        n_good_rx++;

        // transmit length shrinks mid-frame: next byte closes the frame
        send_item(CMD_TX, 8'h3C);
        send_item(CMD_TX, 8'hC3);
        wait_drained();
        reg_write(REG_TX_LENGTH, 8'd1);
        send_item(CMD_TX, 8'h5A);
        n_resize += 2;
        next_tx = 1'b0;

        for (p = 0; p < 4; p++)
        begin
            wait_drained();
            case (p)
                0:
                begin
                    src_gap_pct    <= 0;
                    sink_stall_pct <= 0;
                end
                1:
                begin
                    src_gap_pct    <= 69;
                    sink_stall_pct <= 0;
                end
                2:
                begin
                    src_gap_pct    <= 0;
                    sink_stall_pct <= 69;
                end
                default:
                begin
                    src_gap_pct    <= 32;
                    sink_stall_pct <= 32;
                end
            endcase
            reg_write(REG_HELLO_LENGTH, 8'($urandom_range(255)));
            if (p == 0)
            begin
                // longest transmit frame and a receive length past the store depth
                resize_on = 1'b0;
                reg_write(REG_TX_LENGTH, 8'd255);
                reg_write(REG_RX_LENGTH, 8'd31);
            end
            else
            begin
                resize_on = 1'b1;
                reg_write(REG_TX_LENGTH, pick_tx_length());
                reg_write(REG_RX_LENGTH, pick_rx_length());
            end
            phase_start = n_sent;
            while (n_sent - phase_start < ITEMS_PER_PHASE)
            begin
                if (next_tx)
                    tx_frame();
                else
                    rx_frame();
            end
        end

        wait_drained();
        $display("Covered %0d transactions (%0d in the wrong frame phase), %0d results checked.",
                 n_sent, n_phase_err, results_seen);
        $display("Receive frames: %0d with good checksum, %0d rejected; %0d mid-frame resizes.",
                 n_good_rx, n_bad_rx, n_resize);
        if (fail_count == 0 && pending == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial
    begin : watchdog
        #20_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule
